### rtl/psde_pkg.sv
// ----------------------------------------------------------------------------
// psde_pkg
// Shared constants of the point set diameter estimator: the result width, its
// saturation value and the controller state codes.
// ----------------------------------------------------------------------------
package psde_pkg;

  // Width of the diameter result and the largest value it can carry.
  localparam int DIAM_W = 25;
  localparam logic [DIAM_W-1:0] DIAM_MAX = {DIAM_W{1'b1}};

  // Controller states.
  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;
  localparam logic [1:0] ST_ROOT = 2'd3;

endpackage

### rtl/point_set_diameter_estimator.sv
// ----------------------------------------------------------------------------
// point_set_diameter_estimator
// Stores the vertices of a multipolygon and, on the last word of a set,
// estimates its diameter by repeated farthest-point passes over the store,
// then returns the floor square root of the largest squared distance.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   coord_x coord_y carries_point
//                                           polygon_start last_item
//   out      output     out_valid/out_stall diameter overflow
//
// Loading accepts one word per cycle while the block is in its load state.
// After the last word each pass reads the store once, streaming the stored
// points through the memory port and the distance pipeline, then chooses the
// next anchor; the root is then formed in the digit-serial unit and loaded
// into the output register. The store needs no clearing after reset: only
// entries written in the current set are read. in_stall is high from the last
// word until the result enters the output register; a result waiting there
// does not hold up loading of the next set.
// ----------------------------------------------------------------------------
module point_set_diameter_estimator #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COORD_BITS-1:0]      coord_x,
  input  logic signed [COORD_BITS-1:0]      coord_y,
  input  logic                              carries_point,
  input  logic                              polygon_start,
  input  logic                              last_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [psde_pkg::DIAM_W-1:0]       diameter,
  output logic                              overflow
);

  localparam int AW     = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int PT_W   = 2 * COORD_BITS;
  localparam int PROD_W = 2 * (COORD_BITS + 1);
  localparam int SQ_W   = PROD_W + 1;
  localparam int ROOT_W = COORD_BITS + 2;
  localparam int VAL_W  = 2 * ROOT_W;
  localparam int EXT_W  = (ROOT_W > psde_pkg::DIAM_W) ? ROOT_W : psde_pkg::DIAM_W;

  logic [1:0]                   state;
  logic [CNT_W-1:0]             count;
  logic [CNT_W-1:0]             count_next;
  logic                         have_start;
  logic                         dropped;
  logic signed [COORD_BITS-1:0] ax;
  logic signed [COORD_BITS-1:0] ay;
  logic signed [COORD_BITS-1:0] ax_next;
  logic signed [COORD_BITS-1:0] ay_next;
  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;
  logic signed [COORD_BITS-1:0] cx;
  logic signed [COORD_BITS-1:0] cy;
  logic                         cand_valid;
  logic [SQ_W-1:0]              max_sq;
  logic [CNT_W-1:0]             idx;
  logic                         issue_done;
  logic [CNT_W-1:0]             ret;

  logic                         in_accept;
  logic                         store_we;
  logic                         take_start;
  logic                         rd_en;
  logic                         rd_valid;
  logic [PT_W-1:0]              rd_data;

  logic                         sq_valid;
  logic [PROD_W-1:0]            sq_x;
  logic [PROD_W-1:0]            sq_y;
  logic [PT_W-1:0]              sq_pt;
  logic [SQ_W-1:0]              sq_sum;
  logic                         farther;
  logic                         pass_end;
  logic                         stop;

  logic                         root_start;
  logic                         root_done;
  logic [ROOT_W-1:0]            root;
  logic [EXT_W-1:0]             root_ext;
  logic [psde_pkg::DIAM_W-1:0]  diam_sat;
  logic                         out_load;

  // Input handshake and store write decision.
  assign in_stall   = (state != psde_pkg::ST_LOAD);
  assign in_accept  = in_valid && !in_stall;
  assign store_we   = in_accept && carries_point && (count < CNT_W'(MAX_POINTS));
  assign take_start = store_we && (polygon_start || !have_start);
  assign count_next = store_we ? count + CNT_W'(1) : count;
  assign ax_next    = take_start ? coord_x : ax;
  assign ay_next    = take_start ? coord_y : ay;

  // Read issue: one address a cycle through the stored points.
  assign rd_en = (state == psde_pkg::ST_SCAN) && !issue_done;

  psde_store #(
    .DEPTH(MAX_POINTS),
    .DW   (PT_W)
  ) u_store (
    .clk  (clk),
    .we   (store_we),
    .waddr(count[AW-1:0]),
    .wdata({coord_x, coord_y}),
    .re   (rd_en),
    .raddr(idx[AW-1:0]),
    .rdata(rd_data)
  );

  psde_dist #(
    .COORD_BITS(COORD_BITS)
  ) u_dist (
    .clk     (clk),
    .rst     (rst),
    .anchor_x(ax),
    .anchor_y(ay),
    .pt_valid(rd_valid),
    .pt      (rd_data),
    .sq_valid(sq_valid),
    .sq_x    (sq_x),
    .sq_y    (sq_y),
    .sq_pt   (sq_pt)
  );

  // Sum of squares against the running maximum.
  assign sq_sum   = SQ_W'(sq_x) + SQ_W'(sq_y);
  assign farther  = sq_valid && (sq_sum > max_sq);
  assign pass_end = sq_valid && (ret == count - CNT_W'(1));

  // End of pass: no candidate yet, or the candidate is the previous anchor.
  assign stop = !cand_valid || (cx == px && cy == py);

  // The root starts on the last word of an empty set or when the passes end.
  assign root_start = ((state == psde_pkg::ST_LOAD) && in_accept && last_item
                       && count_next == '0)
                    || ((state == psde_pkg::ST_EVAL) && stop);

  psde_isqrt #(
    .ROOT_W(ROOT_W)
  ) u_isqrt (
    .clk    (clk),
    .rst    (rst),
    .start  (root_start),
    .operand(VAL_W'(max_sq)),
    .done   (root_done),
    .root   (root)
  );

  // Saturate the root to the result width.
  assign root_ext = EXT_W'(root);
  assign diam_sat = (root_ext > EXT_W'(psde_pkg::DIAM_MAX)) ? psde_pkg::DIAM_MAX
                                                            : root_ext[psde_pkg::DIAM_W-1:0];
  assign out_load = (state == psde_pkg::ST_ROOT) && root_done
                    && (!out_valid || !out_stall);

  // Read data is valid in the cycle after the address.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
    end
  end

  // Controller and set state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= psde_pkg::ST_LOAD;
      count      <= '0;
      have_start <= 1'b0;
      dropped    <= 1'b0;
      cand_valid <= 1'b0;
      max_sq     <= '0;
      idx        <= '0;
      issue_done <= 1'b0;
      ret        <= '0;
      ax         <= '0;
      ay         <= '0;
    end else begin
      case (state)
        psde_pkg::ST_LOAD: begin
          if (in_accept) begin
            count      <= count_next;
            ax         <= ax_next;
            ay         <= ay_next;
            have_start <= have_start || take_start;
            if (carries_point && !store_we) begin
              dropped <= 1'b1;
            end
            if (last_item) begin
              idx        <= '0;
              issue_done <= 1'b0;
              ret        <= '0;
              state      <= (count_next == '0) ? psde_pkg::ST_ROOT : psde_pkg::ST_SCAN;
            end
          end
        end
        psde_pkg::ST_SCAN: begin
          if (rd_en) begin
            idx <= idx + CNT_W'(1);
            if (idx == count - CNT_W'(1)) begin
              issue_done <= 1'b1;
            end
          end
          if (farther) begin
            max_sq     <= sq_sum;
            cand_valid <= 1'b1;
          end
          if (sq_valid) begin
            ret <= ret + CNT_W'(1);
          end
          if (pass_end) begin
            state <= psde_pkg::ST_EVAL;
          end
        end
        psde_pkg::ST_EVAL: begin
          if (stop) begin
            state <= psde_pkg::ST_ROOT;
          end else begin
            ax         <= cx;
            ay         <= cy;
            idx        <= '0;
            issue_done <= 1'b0;
            ret        <= '0;
            state      <= psde_pkg::ST_SCAN;
          end
        end
        psde_pkg::ST_ROOT: begin
          if (out_load) begin
            count      <= '0;
            have_start <= 1'b0;
            dropped    <= 1'b0;
            cand_valid <= 1'b0;
            max_sq     <= '0;
            ax         <= '0;
            ay         <= '0;
            state      <= psde_pkg::ST_LOAD;
          end
        end
        default: begin
          state <= psde_pkg::ST_LOAD;
        end
      endcase
    end
  end

  // Previous anchor and candidate coordinates.
  always_ff @(posedge clk) begin
    if (state == psde_pkg::ST_LOAD && in_accept && last_item) begin
      px <= ax_next;
      py <= ay_next;
    end else if (state == psde_pkg::ST_EVAL && !stop) begin
      px <= ax;
      py <= ay;
    end
    if (farther) begin
      cx <= sq_pt[PT_W-1:COORD_BITS];
      cy <= sq_pt[COORD_BITS-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      diameter <= diam_sat;
      overflow <= dropped;
    end
  end

  // The running maximum only grows within a pass.
  a_max_grows: assert property (@(posedge clk) disable iff (rst)
    (state == psde_pkg::ST_SCAN && $past(state) == psde_pkg::ST_SCAN)
      |-> max_sq >= $past(max_sq))
    else $error("running maximum fell during a pass");

  // Reads stay inside the filled part of the store.
  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (idx < count))
    else $error("store read beyond the stored points");

  // No more distances return in a pass than points were stored.
  a_ret_in_range: assert property (@(posedge clk) disable iff (rst)
    sq_valid |-> (ret < count))
    else $error("distance returned beyond the stored points");

  // The fill count never passes the store depth.
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_POINTS))
    else $error("point count beyond store depth");

endmodule

### rtl/psde_store.sv
// ----------------------------------------------------------------------------
// psde_store
// Point store: one write port and one read port, read data registered, so a
// read returns its word in the cycle after the address is presented.
// ----------------------------------------------------------------------------
module psde_store #(
  parameter int DEPTH = 1024,
  parameter int DW    = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/psde_dist.sv
// ----------------------------------------------------------------------------
// psde_dist
// Two-stage squared distance unit. The first stage forms the absolute
// coordinate differences to the anchor, the second squares them. The sum is
// left to the caller, where it meets the running maximum.
// ----------------------------------------------------------------------------
module psde_dist #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic signed [COORD_BITS-1:0] anchor_x,
  input  logic signed [COORD_BITS-1:0] anchor_y,
  input  logic                         pt_valid,
  input  logic [2*COORD_BITS-1:0]      pt,
  output logic                         sq_valid,
  output logic [2*COORD_BITS+1:0]      sq_x,
  output logic [2*COORD_BITS+1:0]      sq_y,
  output logic [2*COORD_BITS-1:0]      sq_pt
);

  localparam int MAG_W = COORD_BITS + 1;
  localparam int PT_W  = 2 * COORD_BITS;

  logic signed [MAG_W-1:0] dx;
  logic signed [MAG_W-1:0] dy;
  logic [MAG_W-1:0]        mag_x;
  logic [MAG_W-1:0]        mag_y;
  logic [PT_W-1:0]         pt_a;
  logic                    valid_a;

  // Differences at one bit wider than a coordinate, so they cannot wrap.
  always_comb begin
    dx = {anchor_x[COORD_BITS-1], anchor_x}
       - {pt[PT_W-1], pt[PT_W-1:COORD_BITS]};
    dy = {anchor_y[COORD_BITS-1], anchor_y}
       - {pt[COORD_BITS-1], pt[COORD_BITS-1:0]};
  end

  // Stage one: magnitudes.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else begin
      valid_a <= pt_valid;
    end
  end

  always_ff @(posedge clk) begin
    mag_x <= dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
    mag_y <= dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
    pt_a  <= pt;
  end

  // Stage two: squares.
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else begin
      sq_valid <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    sq_x  <= mag_x * mag_x;
    sq_y  <= mag_y * mag_y;
    sq_pt <= pt_a;
  end

endmodule

### rtl/psde_isqrt.sv
// ----------------------------------------------------------------------------
// psde_isqrt
// Floor square root, one result bit per cycle by the restoring digit method.
// A start pulse latches the operand; done rises once the last digit step is
// taken and holds with the root until the next start.
// ----------------------------------------------------------------------------
module psde_isqrt #(
  parameter int ROOT_W = 26
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [2*ROOT_W-1:0] operand,
  output logic                done,
  output logic [ROOT_W-1:0]   root
);

  localparam int VAL_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int STEP_W = $clog2(ROOT_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [VAL_W-1:0]  val;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              fits;

  // One digit step: bring down two operand bits and try a one.
  always_comb begin
    rem_sh = {rem[ROOT_W-1:0], val[VAL_W-1 -: 2]};
    trial  = {root, 2'b01};
    fits   = (rem_sh >= trial);
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && steps == STEP_W'(1)) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      val   <= operand;
      rem   <= '0;
      root  <= '0;
      steps <= STEP_W'(ROOT_W);
    end else if (busy) begin
      val   <= {val[VAL_W-3:0], 2'b00};
      rem   <= fits ? rem_sh - trial : rem_sh;
      root  <= {root[ROOT_W-2:0], fits};
      steps <= steps - STEP_W'(1);
    end
  end

endmodule
